FILE: src/ogsf_pkg.sv
// ----------------------------------------------------------------------------
// ogsf_pkg
// Shared types and constants of the occupancy grid shape fill block.
// ----------------------------------------------------------------------------
package ogsf_pkg;

   localparam int OGSF_MAX_COLS = 64;
   localparam int OGSF_MAX_ROWS = 64;

   localparam int COORD_W = 6;
   localparam int DIM_W   = 7;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   // register indexes on the csr port
   localparam logic REG_COLS_IN_USE = 1'b0;
   localparam logic REG_ROWS_IN_USE = 1'b1;

   // request kinds
   localparam logic [1:0] KIND_TRIANGLE  = 2'd0;
   localparam logic [1:0] KIND_RECTANGLE = 2'd1;
   localparam logic [1:0] KIND_QUERY     = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SHARED  = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } ogsf_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_FILL,
      S_FLUSH,
      S_QWAIT,
      S_DONE
   } ogsf_state_type;

   // command from the sequencer to the row memory
   typedef struct packed {
      logic clear;
      logic read;
      logic mark;
   } ogsf_mem_cmd_type;

endpackage

FILE: src/occupancy_grid_shape_fill.sv
// ----------------------------------------------------------------------------
// occupancy_grid_shape_fill
// Blocked-cell bitmap for a planning grid with triangle and rectangle fills
// and single-cell queries.
// ----------------------------------------------------------------------------
//  channel   ports                          role
//  req       req_valid/req_ready + fields   kind, corner / edge coordinates
//  rsp       rsp_valid/rsp_ready + fields   status, cell_blocked
//  csr       csr_psel..csr_pready           cols_in_use @0x0, rows_in_use @0x4
//
//  fill: check, one fill state per row marked, flush and done, then rsp_valid;
//  the row memory read-modify-write marks one bitmap row per cycle, and
//  req_ready rises in the same cycle as rsp_valid. query: check, row read,
//  done. errors, inverted rectangles and the unused kind: check, done.
//  one request is in work at a time.
//  after reset the memory is cleared one row a cycle, all MAX_ROWS rows, with
//  req_ready low; csr writes are taken throughout.
//  a waiting response is held in the output register; the next request is
//  accepted meanwhile and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module occupancy_grid_shape_fill
   import ogsf_pkg::*;
#(
   parameter int MAX_COLS = OGSF_MAX_COLS,
   parameter int MAX_ROWS = OGSF_MAX_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [COORD_W-1:0]  req_first_x,
   input  logic [COORD_W-1:0]  req_first_y,
   input  logic [COORD_W-1:0]  req_second_x,
   input  logic [COORD_W-1:0]  req_second_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic                rsp_cell_blocked,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int RW = $clog2(MAX_ROWS);

   logic [DIM_W-1:0]    cols_ff, cols_in, rows_ff, rows_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic                rsp_cell_ff;
   logic                csr_wr;
   logic                out_free;
   logic                done;
   logic [1:0]          res_status;
   logic                res_cell;
   ogsf_mem_cmd_type    mem_cmd;
   logic [RW-1:0]       mem_addr;
   logic [MAX_COLS-1:0] mem_mask;
   logic [MAX_COLS-1:0] mem_rd_data;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_COLS_IN_USE) begin
            cols_in = csr_pwdata[DIM_W-1:0];
         end else begin
            rows_in = csr_pwdata[DIM_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ROWS_IN_USE) ?
                       {{(CSR_DW-DIM_W){1'b0}}, rows_ff} :
                       {{(CSR_DW-DIM_W){1'b0}}, cols_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= DIM_RESET;
         rows_ff      <= DIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response register
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff <= res_status;
         rsp_cell_ff   <= res_cell;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_cell_blocked = rsp_cell_ff;

   ogsf_ctrl #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .cols_in_use  (cols_ff),
      .rows_in_use  (rows_ff),
      .out_free     (out_free),
      .done         (done),
      .res_status   (res_status),
      .res_cell     (res_cell),
      .mem_cmd      (mem_cmd),
      .mem_addr     (mem_addr),
      .mem_mask     (mem_mask),
      .mem_rd_data  (mem_rd_data)
   );

   ogsf_row_mem #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .mask    (mem_mask),
      .rd_data (mem_rd_data)
   );

endmodule

FILE: src/ogsf_row_mem.sv
// ----------------------------------------------------------------------------
// ogsf_row_mem
// Bitmap row memory with a read-modify-write path that ORs a span mask into
// a row in the cycle after it was read.
// ----------------------------------------------------------------------------
module ogsf_row_mem
   import ogsf_pkg::*;
#(
   parameter int MAX_COLS = OGSF_MAX_COLS,
   parameter int MAX_ROWS = OGSF_MAX_ROWS,
   localparam int RW = $clog2(MAX_ROWS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ogsf_mem_cmd_type      cmd,
   input  logic [RW-1:0]         addr,
   input  logic [MAX_COLS-1:0]   mask,
   output logic [MAX_COLS-1:0]   rd_data
);

   logic [MAX_COLS-1:0] mem [MAX_ROWS];
   logic [MAX_COLS-1:0] rd_data_ff;
   logic                mark_pend_ff;
   logic [RW-1:0]       mark_addr_ff;
   logic [MAX_COLS-1:0] mask_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[addr] <= '0;
      end else if (mark_pend_ff) begin
         mem[mark_addr_ff] <= rd_data_ff | mask_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[addr];
      end
      mark_addr_ff <= addr;
      mask_ff      <= mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_pend_ff <= 1'b0;
      end else begin
         mark_pend_ff <= cmd.mark;
      end
   end

   assign rd_data = rd_data_ff;

   // the write-back of one row never collides with the clear sweep
   a_no_clear_during_mark: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear && mark_pend_ff))
      else $error("clear and mark write-back in the same cycle");

   // the next row read never hits the row still being written back
   a_no_raw_same_row: assert property (@(posedge clock) disable iff (reset)
      (mark_pend_ff && cmd.read) |-> (addr != mark_addr_ff))
      else $error("row read while its write-back is pending");

   // a mark always comes with the read of that row
   a_mark_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |-> cmd.read)
      else $error("mark issued without a row read");

endmodule

FILE: src/ogsf_ctrl.sv
// ----------------------------------------------------------------------------
// ogsf_ctrl
// Sequencer: checks a request, then for a fill steps a shared row/span unit
// one bitmap row per cycle, and sweeps the memory clear after reset.
// ----------------------------------------------------------------------------
module ogsf_ctrl
   import ogsf_pkg::*;
#(
   parameter int MAX_COLS = OGSF_MAX_COLS,
   parameter int MAX_ROWS = OGSF_MAX_ROWS,
   localparam int RW = $clog2(MAX_ROWS),
   localparam int CW = $clog2(MAX_COLS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [COORD_W-1:0]    req_first_x,
   input  logic [COORD_W-1:0]    req_first_y,
   input  logic [COORD_W-1:0]    req_second_x,
   input  logic [COORD_W-1:0]    req_second_y,
   input  logic [DIM_W-1:0]      cols_in_use,
   input  logic [DIM_W-1:0]      rows_in_use,
   input  logic                  out_free,
   output logic                  done,
   output logic [1:0]            res_status,
   output logic                  res_cell,
   output ogsf_mem_cmd_type      mem_cmd,
   output logic [RW-1:0]         mem_addr,
   output logic [MAX_COLS-1:0]   mem_mask,
   input  logic [MAX_COLS-1:0]   mem_rd_data
);

   localparam logic [DIM_W-1:0] ColCap = DIM_W'(MAX_COLS);
   localparam logic [DIM_W-1:0] RowCap = DIM_W'((MAX_ROWS > 127) ? 127 : MAX_ROWS);
   localparam logic [DIM_W-1:0] ColTop = DIM_W'(MAX_COLS - 1);
   localparam logic [RW-1:0]    RowLast = RW'(MAX_ROWS - 1);

   ogsf_state_type      state_ff, state_in;
   logic [1:0]          kind_ff, kind_in;
   logic [COORD_W-1:0]  x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [COORD_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, cnt_ff, cnt_in;
   logic                down_ff, down_in, right_ff, right_in, tri_ff, tri_in;
   ogsf_status_type     status_ff, status_in;
   logic                cell_ff, cell_in;

   logic [DIM_W-1:0]    cols_lim, rows_lim;
   logic                in_first, in_second;
   logic                right_dir, down_dir;
   logic [COORD_W-1:0]  dx, dy;
   logic [DIM_W-1:0]    shr;
   logic [MAX_COLS-1:0] ones;

   assign cols_lim = (cols_in_use < ColCap) ? cols_in_use : ColCap;
   assign rows_lim = (rows_in_use < RowCap) ? rows_in_use : RowCap;
   assign in_first  = ({1'b0, x0_ff} < cols_lim) && ({1'b0, y0_ff} < rows_lim);
   assign in_second = ({1'b0, x1_ff} < cols_lim) && ({1'b0, y1_ff} < rows_lim);
   assign right_dir = x1_ff > x0_ff;
   assign down_dir  = y1_ff > y0_ff;
   assign dx = right_dir ? (x1_ff - x0_ff) : (x0_ff - x1_ff);
   assign dy = down_dir ? (y1_ff - y0_ff) : (y0_ff - y1_ff);

   // span unit: bits lo..hi of one row
   assign ones     = '1;
   assign shr      = ColTop - {1'b0, hi_ff};
   assign mem_mask = (ones << lo_ff) & (ones >> shr);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      cnt_ff    <= cnt_in;
      down_ff   <= down_in;
      right_ff  <= right_in;
      tri_ff    <= tri_in;
      status_ff <= status_in;
      cell_ff   <= cell_in;
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      row_in    = row_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      cnt_in    = cnt_ff;
      down_in   = down_ff;
      right_in  = right_ff;
      tri_in    = tri_ff;
      status_in = status_ff;
      cell_in   = cell_ff;
      req_ready = 1'b0;
      done      = 1'b0;
      mem_cmd   = '0;
      mem_addr  = row_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_cmd.clear = 1'b1;
            row_in = row_ff + RW'(1);
            if (row_ff == RowLast) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_kind;
               x0_in    = req_first_x;
               y0_in    = req_first_y;
               x1_in    = req_second_x;
               y1_in    = req_second_y;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = STATUS_OK;
            cell_in   = 1'b0;
            state_in  = S_DONE;
            case (kind_ff)
               KIND_QUERY: begin
                  if (!in_first) begin
                     status_in = STATUS_OUTSIDE;
                  end else begin
                     mem_cmd.read = 1'b1;
                     mem_addr     = RW'(y0_ff);
                     state_in     = S_QWAIT;
                  end
               end
               KIND_TRIANGLE: begin
                  if (!(in_first && in_second)) begin
                     status_in = STATUS_OUTSIDE;
                  end else if (x0_ff == x1_ff || y0_ff == y1_ff) begin
                     status_in = STATUS_SHARED;
                  end else begin
                     row_in   = RW'(y0_ff);
                     lo_in    = x0_ff;
                     hi_in    = x0_ff;
                     cnt_in   = (dx < dy) ? dx : dy;
                     down_in  = down_dir;
                     right_in = right_dir;
                     tri_in   = 1'b1;
                     state_in = S_FILL;
                  end
               end
               KIND_RECTANGLE: begin
                  if (!(in_first && in_second)) begin
                     status_in = STATUS_OUTSIDE;
                  end else if (x0_ff <= x1_ff && y0_ff <= y1_ff) begin
                     row_in   = RW'(y0_ff);
                     lo_in    = x0_ff;
                     hi_in    = x1_ff;
                     cnt_in   = y1_ff - y0_ff;
                     down_in  = 1'b1;
                     right_in = 1'b1;
                     tri_in   = 1'b0;
                     state_in = S_FILL;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         S_FILL: begin
            // one row per cycle: read now, OR the span in on the next cycle
            mem_cmd.read = 1'b1;
            mem_cmd.mark = 1'b1;
            row_in = down_ff ? (row_ff + RW'(1)) : (row_ff - RW'(1));
            if (tri_ff) begin
               if (right_ff) begin
                  hi_in = hi_ff + COORD_W'(1);
               end else begin
                  lo_in = lo_ff - COORD_W'(1);
               end
            end
            cnt_in = cnt_ff - COORD_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_DONE;
         end
         S_QWAIT: begin
            cell_in  = mem_rd_data[x0_ff[CW-1:0]];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_status = status_ff;
   assign res_cell   = cell_ff;

   // the fill only leaves through the flush cycle
   a_fill_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |=> (state_ff == S_FILL || state_ff == S_FLUSH))
      else $error("fill left without flush");

   // every marked span is well formed
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.mark |-> (lo_ff <= hi_ff))
      else $error("span with low edge above high edge");

   // a query result never reports a blocked cell together with an error
   a_cell_ok_only: assert property (@(posedge clock) disable iff (reset)
      done && res_cell |-> (res_status == STATUS_OK && kind_ff == KIND_QUERY))
      else $error("blocked cell reported outside a good query");

endmodule

FILE: test/ogsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogsf_checker
// Watches the request, response and register ports of the shape fill block,
// keeps its own copy of the blocked-cell map and grid size, predicts the
// response of every accepted request and compares the responses in order.
// ----------------------------------------------------------------------------
module ogsf_checker
   import ogsf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [COORD_W-1:0]  req_first_x,
   input  logic [COORD_W-1:0]  req_first_y,
   input  logic [COORD_W-1:0]  req_second_x,
   input  logic [COORD_W-1:0]  req_second_y,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [1:0]          rsp_status,
   input  logic                rsp_cell_blocked,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic                csr_pready,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output int                  fail_count
);

   typedef struct packed {
      ogsf_status_type status;
      logic            blocked;
   } grid_result_type;

   logic [OGSF_MAX_COLS-1:0] blocked_rows [OGSF_MAX_ROWS];
   logic [DIM_W-1:0]         cols_in_use;
   logic [DIM_W-1:0]         rows_in_use;
   grid_result_type          pending_results [$];
   int                       error_total = 0;

   function automatic void mark_span(int row, int lo, int hi);
      for (int c = lo; c <= hi; c++) blocked_rows[row][c] = 1'b1;
   endfunction

   // appends one predicted response behind the ones still outstanding
   function automatic void add_prediction(grid_result_type res);
      pending_results.insert(pending_results.size(), res);
   endfunction

   // applies one request to the map and returns the response it should give
   function automatic grid_result_type apply_shape(logic [1:0] kind, int ax, int ay,
                                                   int bx, int by);
      grid_result_type res;
      int              cols;
      int              rows;
      int              span;
      int              row;
      logic            a_in;
      logic            b_in;
      logic            right;
      logic            down;
      res.status  = STATUS_OK;
      res.blocked = 1'b0;
      cols = (int'(cols_in_use) > OGSF_MAX_COLS) ? OGSF_MAX_COLS : int'(cols_in_use);
      rows = (int'(rows_in_use) > OGSF_MAX_ROWS) ? OGSF_MAX_ROWS : int'(rows_in_use);
      a_in = (ax < cols) && (ay < rows);
      b_in = (bx < cols) && (by < rows);
      case (kind)
         KIND_QUERY: begin
            // only the first point is checked for a query
            if (!a_in) res.status = STATUS_OUTSIDE;
            else res.blocked = blocked_rows[ay][ax];
         end
         KIND_TRIANGLE: begin
            // grid error wins over shared row or column
            if (!a_in || !b_in) res.status = STATUS_OUTSIDE;
            else if (ax == bx || ay == by) res.status = STATUS_SHARED;
            else begin
               right = bx > ax;
               down  = by > ay;
               span  = right ? bx - ax : ax - bx;
               if ((down ? by - ay : ay - by) < span) span = down ? by - ay : ay - by;
               for (int k = 0; k <= span; k++) begin
                  row = down ? ay + k : ay - k;
                  if (right) mark_span(row, ax, ax + k);
                  else mark_span(row, ax - k, ax);
               end
            end
         end
         KIND_RECTANGLE: begin
            // an inverted range marks nothing and is still ok
            if (!a_in || !b_in) res.status = STATUS_OUTSIDE;
            else if (ax <= bx && ay <= by)
               for (int y = ay; y <= by; y++) mark_span(y, ax, bx);
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic flag_error(string what, int want, int got);
      error_total++;
      $display("%0d ns: %s expected %0d got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      grid_result_type want;
      if (reset) begin
         for (int r = 0; r < OGSF_MAX_ROWS; r++) blocked_rows[r] = '0;
         cols_in_use = DIM_RESET;
         rows_in_use = DIM_RESET;
         pending_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_COLS_IN_USE) cols_in_use = csr_pwdata[DIM_W-1:0];
            else rows_in_use = csr_pwdata[DIM_W-1:0];
         end
         // responses first, a request accepted now cannot be answered yet
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               flag_error("response with nothing pending, outstanding", 0, 1);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  flag_error("status", want.status, rsp_status);
               if (rsp_cell_blocked !== want.blocked)
                  flag_error("cell_blocked", want.blocked, rsp_cell_blocked);
            end
         end
         if (req_valid && req_ready)
            add_prediction(apply_shape(req_kind, int'(req_first_x), int'(req_first_y),
                                       int'(req_second_x), int'(req_second_y)));
      end
      fail_count <= error_total + pending_results.size();
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the occupancy grid shape fill block: directed fills and queries
// at the grid edges, then random phases over a range of grid sizes, with
// bursty requests and a stalling response side. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb
   import ogsf_pkg::*;
();

   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_kind = KIND_QUERY;
   logic [COORD_W-1:0]  req_first_x = '0;
   logic [COORD_W-1:0]  req_first_y = '0;
   logic [COORD_W-1:0]  req_second_x = '0;
   logic [COORD_W-1:0]  req_second_y = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic                rsp_cell_blocked;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;
   int                  fail_count;

   int req_count = 0;
   int rsp_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   occupancy_grid_shape_fill u_top (.*);

   ogsf_checker u_checker (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) rsp_count <= rsp_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: always ready, random, or mostly stalled, for random stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 160);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic int pick_coord(int limit);
      if (limit == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, limit - 1);
   endfunction

   // a coordinate a few cells around base, clamped to the grid, at times a random pick
   function automatic int near_coord(int base, int limit);
      int v;
      int top;
      if ($urandom_range(0, 7) == 0) return pick_coord(limit);
      top = (limit == 0) ? 63 : limit - 1;
      v = base + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
   endfunction

   task automatic issue_request(input logic [1:0] kind, input int ax, input int ay,
                                input int bx, input int by);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_first_x  <= ax[COORD_W-1:0];
      req_first_y  <= ay[COORD_W-1:0];
      req_second_x <= bx[COORD_W-1:0];
      req_second_y <= by[COORD_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 20);
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (rsp_count != req_count);
   endtask

   task automatic write_register(input logic index, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      // upper bits carry junk, only the low field is kept
      csr_pwdata  <= ($urandom << DIM_W) | (value & 32'h7f);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input int cols, input int rows);
      write_register(REG_COLS_IN_USE, cols);
      write_register(REG_ROWS_IN_USE, rows);
   endtask

   task automatic run_phase(input int cols, input int rows, input int count);
      int         eff_cols;
      int         eff_rows;
      int         pick;
      int         ax;
      int         ay;
      int         bx;
      int         by;
      logic [1:0] kind;
      drain_responses();
      set_grid(cols, rows);
      eff_cols = (cols > OGSF_MAX_COLS) ? OGSF_MAX_COLS : cols;
      eff_rows = (rows > OGSF_MAX_ROWS) ? OGSF_MAX_ROWS : rows;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) kind = KIND_TRIANGLE;
         else if (pick < 55) kind = KIND_RECTANGLE;
         else if (pick < 93) kind = KIND_QUERY;
         else kind = KIND_UNUSED;
         ax = pick_coord(eff_cols);
         ay = pick_coord(eff_rows);
         // rectangles lean toward the lower right so most are well ordered
         if (kind == KIND_RECTANGLE) begin
            bx = near_coord(ax + 3, eff_cols);
            by = near_coord(ay + 3, eff_rows);
         end else begin
            bx = near_coord(ax, eff_cols);
            by = near_coord(ay, eff_rows);
         end
         issue_request(kind, ax, ay, bx, by);
         if ($urandom_range(0, 199) == 0) drain_responses();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full grid from reset: corners, every fill direction, shared points
      issue_request(KIND_QUERY, 0, 0, 0, 0);
      issue_request(KIND_QUERY, 63, 63, 0, 0);
      issue_request(KIND_RECTANGLE, 63, 63, 63, 63);
      issue_request(KIND_RECTANGLE, 40, 0, 40, 63);
      issue_request(KIND_RECTANGLE, 9, 9, 8, 12);
      issue_request(KIND_RECTANGLE, 9, 9, 12, 8);
      issue_request(KIND_TRIANGLE, 0, 0, 5, 9);
      issue_request(KIND_TRIANGLE, 63, 0, 58, 4);
      issue_request(KIND_TRIANGLE, 20, 40, 25, 30);
      issue_request(KIND_TRIANGLE, 30, 50, 27, 47);
      issue_request(KIND_TRIANGLE, 10, 10, 20, 10);
      issue_request(KIND_TRIANGLE, 10, 10, 10, 20);
      issue_request(KIND_TRIANGLE, 12, 12, 12, 12);
      issue_request(KIND_UNUSED, 63, 63, 63, 63);
      issue_request(KIND_QUERY, 1, 1, 63, 63);
      issue_request(KIND_QUERY, 2, 1, 0, 0);
      issue_request(KIND_QUERY, 63, 63, 0, 0);
      issue_request(KIND_QUERY, 40, 33, 0, 0);

      // small grid: edges just past the limits
      drain_responses();
      set_grid(10, 12);
      issue_request(KIND_QUERY, 10, 0, 0, 0);
      issue_request(KIND_QUERY, 0, 12, 0, 0);
      issue_request(KIND_QUERY, 0, 0, 63, 63);
      issue_request(KIND_RECTANGLE, 0, 0, 10, 0);
      issue_request(KIND_TRIANGLE, 3, 3, 3, 15);
      issue_request(KIND_TRIANGLE, 9, 11, 0, 0);
      issue_request(KIND_QUERY, 9, 11, 0, 0);

      run_phase(10, 12, 50);
      run_phase(64, 64, 380);
      run_phase(127, 100, 150);
      run_phase(64, 1, 90);
      run_phase(1, 64, 90);
      run_phase(33, 7, 150);
      run_phase(1, 1, 60);
      run_phase(2, 2, 60);
      run_phase(0, 64, 40);
      run_phase(17, 64, 150);
      run_phase(64, 64, 180);

      drain_responses();
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
